### hdl/clps_pkg.sv
// clps_pkg: shared types and constants for the charlieplexed led scanner
// no dependencies; used by clps_state, clps_phase_dec, charlieplex_led_scanner and tb_top
`timescale 1ns / 1ps

package clps_pkg;

  localparam int unsigned MapBytes  = 3;
  localparam int unsigned NumPins   = 6;
  localparam int unsigned PhaseW    = 3;
  localparam int unsigned IdxW      = 2;
  localparam logic [7:0]  MapReset  = 8'hff;
  localparam logic [2:0]  LastPhase = 3'd5;

  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_WRITE = 1'b1
  } opcode_e;

  typedef logic [NumPins-1:0] pins_t;
  typedef logic [PhaseW-1:0]  phase_t;
  typedef logic [MapBytes-1:0][7:0] seg_map_t;

  // state update issued by the pipeline when an item leaves the input register
  typedef struct packed {
    logic             map_we;
    logic [IdxW-1:0]  map_idx;
    logic [7:0]       map_data;
    logic             phase_adv;
  } state_upd_t;

endpackage

### hdl/clps_state.sv
// clps_state: segment map bytes, scan phase and scan enable registers
// depends on clps_pkg
`timescale 1ns / 1ps

module clps_state (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  clps_pkg::state_upd_t  upd_i,
  input  logic                  cfg_we_i,
  input  logic                  cfg_data_i,
  output clps_pkg::seg_map_t    seg_map_o,
  output clps_pkg::phase_t      phase_o,
  output logic                  scan_en_o
);

  clps_pkg::seg_map_t map_q, map_d;
  clps_pkg::phase_t   phase_q, phase_d;
  logic               scan_en_q, scan_en_d;

  always_comb begin
    map_d     = map_q;
    phase_d   = phase_q;
    scan_en_d = scan_en_q;
    // index three addresses nothing
    if (upd_i.map_we && (upd_i.map_idx < clps_pkg::IdxW'(clps_pkg::MapBytes))) begin
      map_d[upd_i.map_idx] = upd_i.map_data;
    end
    if (upd_i.phase_adv) begin
      phase_d = (phase_q >= clps_pkg::LastPhase) ? '0 : phase_q + 3'd1;
    end
    if (cfg_we_i) begin
      scan_en_d = cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_q     <= {clps_pkg::MapBytes{clps_pkg::MapReset}};
      phase_q   <= '0;
      scan_en_q <= 1'b1;
    end else begin
      map_q     <= map_d;
      phase_q   <= phase_d;
      scan_en_q <= scan_en_d;
    end
  end

  assign seg_map_o = map_q;
  assign phase_o   = phase_q;
  assign scan_en_o = scan_en_q;

endmodule

### hdl/clps_phase_dec.sv
// clps_phase_dec: pin drive and level decode for one scan phase
// depends on clps_pkg
`timescale 1ns / 1ps

module clps_phase_dec (
  input  clps_pkg::seg_map_t seg_map_i,
  input  clps_pkg::phase_t   phase_i,
  input  logic               scan_en_i,
  output clps_pkg::pins_t    drive_o,
  output clps_pkg::pins_t    level_o
);

  logic [7:0] m0, m1, m2;

  assign m0 = seg_map_i[0];
  assign m1 = seg_map_i[1];
  assign m2 = seg_map_i[2];

  always_comb begin
    drive_o = '0;
    level_o = '0;
    if (scan_en_i) begin
      case (phase_i)
        3'd0: begin
          // pin3 low, segments high
          drive_o[2]   = 1'b1;
          drive_o[5:3] = {m2[7], m1[7], m0[7]};
          level_o[5:3] = {m2[7], m1[7], m0[7]};
        end
        3'd1: begin
          drive_o[0]   = 1'b1;
          drive_o[5:1] = m0[4:0];
          level_o[5:1] = m0[4:0];
        end
        3'd2: begin
          // pin1 high, segments low
          drive_o[0]   = 1'b1;
          level_o[0]   = 1'b1;
          drive_o[5:1] = m1[4:0];
        end
        3'd3: begin
          drive_o[1]   = 1'b1;
          drive_o[5:2] = {m1[6], m1[5], m0[6], m0[5]};
          level_o[5:2] = {m1[6], m1[5], m0[6], m0[5]};
        end
        3'd4: begin
          drive_o[1]   = 1'b1;
          level_o[1]   = 1'b1;
          drive_o[5:2] = m2[3:0];
        end
        3'd5: begin
          drive_o[2]   = 1'b1;
          level_o[2]   = 1'b1;
          drive_o[5:3] = m2[6:4];
        end
        default: begin
          drive_o = '0;
          level_o = '0;
        end
      endcase
    end
  end

endmodule

### hdl/charlieplex_led_scanner.sv
// Six-pin charlieplexed led scanner for a 24-segment display. One transaction is
// accepted per clock while in_ready_o is high. An accepted item waits in the input
// register; a tick then loads its result into the result register when it leaves
// the input register, while a map write yields nothing. Throughput is set by the
// result register alone: in_ready_o drops only while a tick waits in the input
// register and the result register holds a result not yet taken. Map writes take
// effect in transaction order; scan_enable is a plain register written whenever
// cfg_we_i is high and resets to 1.
// depends on clps_pkg, clps_state, clps_phase_dec
`timescale 1ns / 1ps

module charlieplex_led_scanner (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       opcode_i,
  input  logic [1:0] map_index_i,
  input  logic [7:0] map_data_i,
  input  logic       cfg_we_i,
  input  logic       cfg_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [5:0] pin_drive_o,
  output logic [5:0] pin_level_o,
  output logic [2:0] scan_phase_out_o
);

  logic                 in_valid_q, in_valid_d;
  clps_pkg::opcode_e    op_q;
  logic [1:0]           idx_q;
  logic [7:0]           data_q;

  logic                 out_valid_q, out_valid_d;
  clps_pkg::pins_t      drive_q, level_q;
  clps_pkg::phase_t     phase_out_q;

  logic                 is_tick;
  logic                 out_free;
  logic                 advance;
  logic                 in_take;

  clps_pkg::state_upd_t upd;
  clps_pkg::seg_map_t   seg_map;
  clps_pkg::phase_t     phase;
  logic                 scan_en;
  clps_pkg::pins_t      drive, level;

  assign is_tick  = (op_q == clps_pkg::OP_TICK);
  assign out_free = !out_valid_q || out_ready_i;
  assign advance  = in_valid_q && (!is_tick || out_free);
  assign in_ready_o = !in_valid_q || advance;
  assign in_take  = in_valid_i && in_ready_o;

  always_comb begin
    upd.map_we    = advance && !is_tick;
    upd.map_idx   = idx_q;
    upd.map_data  = data_q;
    upd.phase_adv = advance && is_tick && scan_en;
  end

  clps_state u_state (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .upd_i      (upd),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .seg_map_o  (seg_map),
    .phase_o    (phase),
    .scan_en_o  (scan_en)
  );

  clps_phase_dec u_dec (
    .seg_map_i (seg_map),
    .phase_i   (phase),
    .scan_en_i (scan_en),
    .drive_o   (drive),
    .level_o   (level)
  );

  always_comb begin
    in_valid_d = in_take || (in_valid_q && !advance);
    if (advance && is_tick) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      op_q   <= clps_pkg::opcode_e'(opcode_i);
      idx_q  <= map_index_i;
      data_q <= map_data_i;
    end
    if (advance && is_tick) begin
      drive_q     <= drive;
      level_q     <= level;
      phase_out_q <= phase;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign pin_drive_o      = drive_q;
  assign pin_level_o      = level_q;
  assign scan_phase_out_o = phase_out_q;

endmodule

### hdl/clps_checker.sv
// clps_checker: port-level assertions for charlieplex_led_scanner, with its bind
// depends on the top level's port list only
`timescale 1ns / 1ps

module clps_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [5:0] pin_drive_o,
  input logic [5:0] pin_level_o,
  input logic [2:0] scan_phase_out_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(pin_drive_o)
      && $stable(pin_level_o) && $stable(scan_phase_out_o))
    else $error("result changed while stalled");

  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> scan_phase_out_o <= 3'd5)
    else $error("scan phase out of range");

  // undriven pins read low
  a_level_in_drive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pin_level_o & ~pin_drive_o) == 6'd0)
    else $error("level set on undriven pin");

  // pin1 is the common pin in phases one and two
  a_pin1_common: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pin_drive_o != 6'd0
      && (scan_phase_out_o == 3'd1 || scan_phase_out_o == 3'd2)
    |-> pin_drive_o[0] && (pin_level_o[0] == (scan_phase_out_o == 3'd2)))
    else $error("pin1 common drive wrong");

endmodule

bind charlieplex_led_scanner clps_checker u_clps_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .pin_drive_o      (pin_drive_o),
  .pin_level_o      (pin_level_o),
  .scan_phase_out_o (scan_phase_out_o)
);

### test/tb_top.sv
// tb_top: self-checking testbench for charlieplex_led_scanner, random and directed items
// keeps its own mirror of the segment map, scan phase and enable; depends on clps_pkg
`timescale 1ns / 1ps

module tb_top;

  typedef struct packed {
    clps_pkg::opcode_e op;
    logic [1:0]        idx;
    logic [7:0]        data;
  } scan_item_t;

  typedef struct packed {
    clps_pkg::pins_t  drive;
    clps_pkg::pins_t  level;
    clps_pkg::phase_t phase;
  } pin_frame_t;

  localparam int unsigned StallLimit = 2000;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_ready_o;
  logic       opcode_i    = clps_pkg::OP_TICK;
  logic [1:0] map_index_i = 2'd0;
  logic [7:0] map_data_i  = 8'd0;
  logic       cfg_we_i    = 1'b0;
  logic       cfg_data_i  = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [5:0] pin_drive_o;
  logic [5:0] pin_level_o;
  logic [2:0] scan_phase_out_o;

  scan_item_t         item_q[$];
  pin_frame_t         due_frames[$];
  scan_item_t         shown;
  clps_pkg::seg_map_t map_mirror;
  clps_pkg::phase_t   phase_mirror;
  logic               enable_mirror;
  logic               idle_on;
  int unsigned        gap_left;
  int unsigned        stall_left;
  int unsigned        quiet_cycles;
  int unsigned        errors;

  charlieplex_led_scanner dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .opcode_i         (opcode_i),
    .map_index_i      (map_index_i),
    .map_data_i       (map_data_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_data_i       (cfg_data_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .pin_drive_o      (pin_drive_o),
    .pin_level_o      (pin_level_o),
    .scan_phase_out_o (scan_phase_out_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // pin pattern of one scan phase for a given segment map
  function automatic pin_frame_t scan_pattern(input clps_pkg::phase_t ph,
                                              input clps_pkg::seg_map_t m);
    pin_frame_t f;
    f = '0;
    f.phase = ph;
    case (ph)
      3'd0: begin
        f.drive[2] = 1'b1;
        f.drive[5:3] = {m[2][7], m[1][7], m[0][7]};
        f.level[5:3] = {m[2][7], m[1][7], m[0][7]};
      end
      3'd1: begin
        f.drive[0] = 1'b1;
        f.drive[5:1] = m[0][4:0];
        f.level[5:1] = m[0][4:0];
      end
      3'd2: begin
        f.drive[0] = 1'b1;
        f.level[0] = 1'b1;
        f.drive[5:1] = m[1][4:0];
      end
      3'd3: begin
        f.drive[1] = 1'b1;
        f.drive[5:2] = {m[1][6], m[1][5], m[0][6], m[0][5]};
        f.level[5:2] = {m[1][6], m[1][5], m[0][6], m[0][5]};
      end
      3'd4: begin
        f.drive[1] = 1'b1;
        f.level[1] = 1'b1;
        f.drive[5:2] = m[2][3:0];
      end
      3'd5: begin
        f.drive[2] = 1'b1;
        f.level[2] = 1'b1;
        f.drive[5:3] = m[2][6:4];
      end
      default: ;
    endcase
    return f;
  endfunction

  // update the mirror for one accepted transaction and queue the frame it yields
  function automatic void predict_item(input scan_item_t it);
    pin_frame_t f;
    if (it.op == clps_pkg::OP_WRITE) begin
      if (it.idx < clps_pkg::MapBytes) map_mirror[it.idx] = it.data;
    end else if (!enable_mirror) begin
      f = '0;
      f.phase = phase_mirror;
      due_frames.push_back(f);
    end else begin
      due_frames.push_back(scan_pattern(phase_mirror, map_mirror));
      phase_mirror = (phase_mirror >= clps_pkg::LastPhase) ? clps_pkg::phase_t'(0)
                                                           : phase_mirror + clps_pkg::phase_t'(1);
    end
  endfunction

  function automatic scan_item_t make_item(input clps_pkg::opcode_e op, input logic [1:0] idx,
                                           input logic [7:0] data);
    scan_item_t it;
    it.op = op;
    it.idx = idx;
    it.data = data;
    return it;
  endfunction

  function automatic scan_item_t rand_item();
    scan_item_t  it;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    it.idx = 2'($urandom_range(0, 2));
    it.data = 8'($urandom_range(0, 255));
    if (pick < 50) begin
      it.op = clps_pkg::OP_TICK;
      it.idx = 2'($urandom_range(0, 3));
    end else if (pick < 95) begin
      it.op = clps_pkg::OP_WRITE;
    end else begin
      it.op = clps_pkg::OP_WRITE;
      it.idx = 2'd3;
    end
    if ($urandom_range(0, 15) == 0) it.data = $urandom_range(0, 1) ? 8'hff : 8'h00;
    return it;
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid_i && in_ready_o) predict_item(shown);
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (idle_on && item_q.size() > 0 && $urandom_range(0, 9) == 0) begin
          gap_left = $urandom_range(0, 13);
          in_valid_i <= 1'b0;
        end else if (item_q.size() > 0) begin
          shown = item_q.pop_front();
          in_valid_i  <= 1'b1;
          opcode_i    <= shown.op;
          map_index_i <= shown.idx;
          map_data_i  <= shown.data;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    pin_frame_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (due_frames.size() == 0) begin
          errors++;
          $display("%0t: frame with nothing due, actual drive %b level %b phase %0d", $time,
                   pin_drive_o, pin_level_o, scan_phase_out_o);
        end else begin
          want = due_frames.pop_front();
          if (pin_drive_o !== want.drive) begin
            errors++;
            $display("%0t: pin_drive expected %b actual %b", $time, want.drive, pin_drive_o);
          end
          if (pin_level_o !== want.level) begin
            errors++;
            $display("%0t: pin_level expected %b actual %b", $time, want.level, pin_level_o);
          end
          if (scan_phase_out_o !== want.phase) begin
            errors++;
            $display("%0t: scan_phase_out expected %0d actual %0d", $time, want.phase,
                     scan_phase_out_o);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 13);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic wait_idle();
    while (item_q.size() > 0 || in_valid_i || due_frames.size() > 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_scan_enable(input logic v);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    enable_mirror = v;
  endtask

  task automatic push_random(input int unsigned n);
    repeat (n) item_q.push_back(rand_item());
  endtask

  initial begin
    errors = 0;
    quiet_cycles = 0;
    idle_on = 1'b0;
    map_mirror = {clps_pkg::MapBytes{clps_pkg::MapReset}};
    phase_mirror = '0;
    enable_mirror = 1'b1;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset map through a full scan, then cleared map, ignored index, mixed bits
    repeat (6) item_q.push_back(make_item(clps_pkg::OP_TICK, 2'd3, 8'hff));
    item_q.push_back(make_item(clps_pkg::OP_WRITE, 2'd0, 8'h00));
    item_q.push_back(make_item(clps_pkg::OP_WRITE, 2'd1, 8'h00));
    item_q.push_back(make_item(clps_pkg::OP_WRITE, 2'd2, 8'h00));
    item_q.push_back(make_item(clps_pkg::OP_WRITE, 2'd3, 8'hff));
    repeat (6) item_q.push_back(make_item(clps_pkg::OP_TICK, 2'd0, 8'h00));
    item_q.push_back(make_item(clps_pkg::OP_WRITE, 2'd0, 8'ha5));
    item_q.push_back(make_item(clps_pkg::OP_WRITE, 2'd1, 8'h5a));
    item_q.push_back(make_item(clps_pkg::OP_WRITE, 2'd2, 8'h3c));
    repeat (2) item_q.push_back(make_item(clps_pkg::OP_TICK, 2'd2, 8'h5a));
    wait_idle();

    // sleep: phase held, writes still land
    set_scan_enable(1'b0);
    item_q.push_back(make_item(clps_pkg::OP_TICK, 2'd1, 8'h00));
    item_q.push_back(make_item(clps_pkg::OP_WRITE, 2'd1, 8'hff));
    item_q.push_back(make_item(clps_pkg::OP_TICK, 2'd0, 8'hff));
    wait_idle();

    set_scan_enable(1'b1);
    idle_on = 1'b1;
    push_random(400);
    wait_idle();

    set_scan_enable(1'b0);
    push_random(250);
    wait_idle();

    set_scan_enable(1'b1);
    push_random(175);
    wait_idle();
    push_random(175);
    wait_idle();

    // closing stretch at full rate
    set_scan_enable(1'b1);
    idle_on = 1'b0;
    push_random(300);
    wait_idle();
    repeat (10) @(posedge clk_i);

    if (errors == 0 && due_frames.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
